// ----- design/gbos_pkg.sv -----
// Package for the greedy box overlap suppression block.
// Holds sizes, the sequencer state type and small box helpers; no dependencies.
`default_nettype none
package gbos_pkg;

    localparam int MAX_BOXES = 1024;
    localparam int MAX_KEEP  = 64;
    localparam int BOX_AW    = $clog2(MAX_BOXES);
    localparam int CNT_W     = BOX_AW + 1;
    localparam int KEEP_AW   = $clog2(MAX_KEEP);
    localparam int KC_W      = KEEP_AW + 1;
    localparam int BOX_W     = 64;
    localparam int THR_W     = 17;

    localparam logic CFG_KEEP_COUNT = 1'b0;
    localparam logic CFG_THRESHOLD  = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE, S_INIT, S_CAND, S_BRD, S_AREAB, S_KRD, S_BOXRD, S_MULI,
        S_MULA, S_UNION, S_MULT, S_FRD, S_FCHK, S_ERD, S_ELOAD, S_EWAIT
    } t_state;

    // Length of an extent; an inverted extent counts as zero.
    function automatic logic [15:0] ext_len(input logic [15:0] lo, input logic [15:0] hi);
        ext_len = (hi > lo) ? (hi - lo) : 16'd0;
    endfunction

    function automatic logic [15:0] max16(input logic [15:0] a, input logic [15:0] b);
        max16 = (a > b) ? a : b;
    endfunction

    function automatic logic [15:0] min16(input logic [15:0] a, input logic [15:0] b);
        min16 = (a < b) ? a : b;
    endfunction

endpackage
`default_nettype wire

// ----- design/gbos_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none
module gbos_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- design/greedy_box_overlap_suppression.sv -----
// Top level of the greedy box overlap suppression block: box loading, the
// selection sequencer with one shared multiplier, and result output. Uses gbos_pkg, gbos_ram.
//
//   Channel   Handshake            Payload
//   input     i_valid / o_stall    i_left_x, i_top_y, i_right_x, i_bottom_y, i_last_box
//   output    o_valid / i_stall    o_selected_index, o_last_selected
//   config    i_cfg_we             i_cfg_idx, i_cfg_data
//
// A box without the last flag is stored as it is accepted. The box carrying the last
// flag starts the selection: each candidate box is checked against every kept box,
// all on one shared 33x17 multiplier, then a fill pass tops up the kept list, then
// each kept index is emitted in turn and held while the receiver stalls.
// Reset is synchronous and active low; it clears the sequencer, the box count and
// the output valid, and loads the config defaults. The box store needs no clearing pass.
// o_stall stays high from the last box until the final index is taken.
`default_nettype none
module greedy_box_overlap_suppression (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [15:0] i_left_x,
    input  wire logic [15:0] i_top_y,
    input  wire logic [15:0] i_right_x,
    input  wire logic [15:0] i_bottom_y,
    input  wire logic        i_last_box,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [9:0]       o_selected_index,
    output logic             o_last_selected,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [16:0] i_cfg_data
);
    gbos_pkg::t_state r_state, n_state;

    logic [6:0]  r_keep_count;
    logic [gbos_pkg::THR_W-1:0] r_thr;

    logic [gbos_pkg::CNT_W-1:0] r_count, n_count;
    logic [gbos_pkg::CNT_W-1:0] r_b, n_b;
    logic [gbos_pkg::KC_W-1:0]  r_kc, n_kc;
    logic [gbos_pkg::KC_W-1:0]  r_want, n_want;
    logic [gbos_pkg::KC_W-1:0]  r_i, n_i;
    logic [gbos_pkg::KC_W-1:0]  r_p, n_p;
    logic [gbos_pkg::KC_W-1:0]  r_g, n_g;
    logic                       r_bad, n_bad;
    logic [63:0] r_boxa, n_boxa, r_boxb, n_boxb;
    logic [31:0] r_areaa, n_areaa, r_areab, n_areab, r_inter, n_inter;
    logic [32:0] r_union, n_union;
    logic [9:0]  r_out_idx, n_out_idx;
    logic        r_out_last, n_out_last, r_out_valid, n_out_valid;

    // Box store and kept list.
    logic                         box_we;
    logic [gbos_pkg::BOX_AW-1:0]  box_waddr, box_raddr;
    logic [63:0]                  box_wdata, box_rdata;
    logic                         kl_we;
    logic [gbos_pkg::KEEP_AW-1:0] kl_waddr, kl_raddr;
    logic [9:0]                   kl_wdata, kl_rdata;

    // Shared multiplier.
    logic [32:0] mul_a;
    logic [16:0] mul_b;
    logic [49:0] mul_p;

    logic [15:0] il, it, ir, id;

    gbos_ram #(.WIDTH(gbos_pkg::BOX_W), .DEPTH(gbos_pkg::MAX_BOXES)) u_box_ram (
        .i_clk(i_clk), .i_we(box_we), .i_waddr(box_waddr), .i_wdata(box_wdata),
        .i_raddr(box_raddr), .o_rdata(box_rdata)
    );

    gbos_ram #(.WIDTH(10), .DEPTH(gbos_pkg::MAX_KEEP)) u_kept_ram (
        .i_clk(i_clk), .i_we(kl_we), .i_waddr(kl_waddr), .i_wdata(kl_wdata),
        .i_raddr(kl_raddr), .o_rdata(kl_rdata)
    );

    assign mul_p = mul_a * mul_b;

    // Intersection edges of the fetched kept box and the candidate.
    assign il = gbos_pkg::max16(box_rdata[15:0],  r_boxb[15:0]);
    assign it = gbos_pkg::max16(box_rdata[31:16], r_boxb[31:16]);
    assign ir = gbos_pkg::min16(box_rdata[47:32], r_boxb[47:32]);
    assign id = gbos_pkg::min16(box_rdata[63:48], r_boxb[63:48]);

    assign o_stall          = (r_state != gbos_pkg::S_IDLE);
    assign o_valid          = r_out_valid;
    assign o_selected_index = r_out_idx;
    assign o_last_selected  = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= gbos_pkg::S_IDLE;
            r_count      <= '0;
            r_out_valid  <= 1'b0;
            r_keep_count <= 7'd64;
            r_thr        <= 17'd32768;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    gbos_pkg::CFG_KEEP_COUNT: r_keep_count <= i_cfg_data[6:0];
                    gbos_pkg::CFG_THRESHOLD:  r_thr        <= i_cfg_data;
                    default:                  r_thr        <= r_thr;
                endcase
            end
        end
        r_b        <= n_b;
        r_kc       <= n_kc;
        r_want     <= n_want;
        r_i        <= n_i;
        r_p        <= n_p;
        r_g        <= n_g;
        r_bad      <= n_bad;
        r_boxa     <= n_boxa;
        r_boxb     <= n_boxb;
        r_areaa    <= n_areaa;
        r_areab    <= n_areab;
        r_inter    <= n_inter;
        r_union    <= n_union;
        r_out_idx  <= n_out_idx;
        r_out_last <= n_out_last;
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_b         = r_b;
        n_kc        = r_kc;
        n_want      = r_want;
        n_i         = r_i;
        n_p         = r_p;
        n_g         = r_g;
        n_bad       = r_bad;
        n_boxa      = r_boxa;
        n_boxb      = r_boxb;
        n_areaa     = r_areaa;
        n_areab     = r_areab;
        n_inter     = r_inter;
        n_union     = r_union;
        n_out_idx   = r_out_idx;
        n_out_last  = r_out_last;
        n_out_valid = r_out_valid;

        box_we    = 1'b0;
        box_waddr = r_count[gbos_pkg::BOX_AW-1:0];
        box_wdata = {i_bottom_y, i_right_x, i_top_y, i_left_x};
        box_raddr = r_b[gbos_pkg::BOX_AW-1:0];
        kl_we     = 1'b0;
        kl_waddr  = r_kc[gbos_pkg::KEEP_AW-1:0];
        kl_wdata  = r_b[9:0];
        kl_raddr  = r_i[gbos_pkg::KEEP_AW-1:0];
        mul_a     = '0;
        mul_b     = '0;

        unique case (r_state)
            gbos_pkg::S_IDLE: begin
                if (i_valid) begin
                    // Boxes past the store's end are dropped.
                    if (r_count < gbos_pkg::CNT_W'(gbos_pkg::MAX_BOXES)) begin
                        box_we  = 1'b1;
                        n_count = r_count + 1'b1;
                    end
                    if (i_last_box) begin
                        if (r_keep_count == 7'd0) begin
                            n_want = gbos_pkg::KC_W'(1);
                        end else if (r_keep_count > 7'(gbos_pkg::MAX_KEEP)) begin
                            n_want = gbos_pkg::KC_W'(gbos_pkg::MAX_KEEP);
                        end else begin
                            n_want = gbos_pkg::KC_W'(r_keep_count);
                        end
                        n_state = gbos_pkg::S_INIT;
                    end
                end
            end
            gbos_pkg::S_INIT: begin
                // Box 0 is always kept.
                kl_we    = 1'b1;
                kl_waddr = '0;
                kl_wdata = '0;
                n_kc     = gbos_pkg::KC_W'(1);
                n_b      = gbos_pkg::CNT_W'(1);
                n_state  = gbos_pkg::S_CAND;
            end
            gbos_pkg::S_CAND: begin
                box_raddr = r_b[gbos_pkg::BOX_AW-1:0];
                if (r_b >= r_count || r_kc >= r_want) begin
                    n_g     = r_kc;
                    n_p     = '0;
                    n_b     = '0;
                    n_state = gbos_pkg::S_FRD;
                end else begin
                    n_state = gbos_pkg::S_BRD;
                end
            end
            gbos_pkg::S_BRD: begin
                n_boxb  = box_rdata;
                n_state = gbos_pkg::S_AREAB;
            end
            gbos_pkg::S_AREAB: begin
                mul_a   = {17'd0, gbos_pkg::ext_len(r_boxb[15:0], r_boxb[47:32])};
                mul_b   = {1'b0, gbos_pkg::ext_len(r_boxb[31:16], r_boxb[63:48])};
                n_areab = mul_p[31:0];
                n_i     = '0;
                n_bad   = 1'b0;
                n_state = gbos_pkg::S_KRD;
            end
            gbos_pkg::S_KRD: begin
                kl_raddr = r_i[gbos_pkg::KEEP_AW-1:0];
                if (r_i == r_kc) begin
                    if (!r_bad) begin
                        kl_we = 1'b1;
                        n_kc  = r_kc + 1'b1;
                    end
                    n_b     = r_b + 1'b1;
                    n_state = gbos_pkg::S_CAND;
                end else begin
                    n_state = gbos_pkg::S_BOXRD;
                end
            end
            gbos_pkg::S_BOXRD: begin
                box_raddr = kl_rdata;
                n_state   = gbos_pkg::S_MULI;
            end
            gbos_pkg::S_MULI: begin
                mul_a   = {17'd0, gbos_pkg::ext_len(il, ir)};
                mul_b   = {1'b0, gbos_pkg::ext_len(it, id)};
                n_inter = mul_p[31:0];
                n_boxa  = box_rdata;
                n_state = gbos_pkg::S_MULA;
            end
            gbos_pkg::S_MULA: begin
                mul_a   = {17'd0, gbos_pkg::ext_len(r_boxa[15:0], r_boxa[47:32])};
                mul_b   = {1'b0, gbos_pkg::ext_len(r_boxa[31:16], r_boxa[63:48])};
                n_areaa = mul_p[31:0];
                n_state = gbos_pkg::S_UNION;
            end
            gbos_pkg::S_UNION: begin
                n_union = {1'b0, r_areaa} + {1'b0, r_areab} - {1'b0, r_inter};
                n_state = gbos_pkg::S_MULT;
            end
            gbos_pkg::S_MULT: begin
                // Suppress when inter * 2^16 exceeds threshold * union.
                mul_a = r_union;
                mul_b = r_thr;
                if ({2'b00, r_inter, 16'h0000} > mul_p) begin
                    n_bad = 1'b1;
                end
                n_i     = r_i + 1'b1;
                n_state = gbos_pkg::S_KRD;
            end
            gbos_pkg::S_FRD: begin
                kl_raddr = r_p[gbos_pkg::KEEP_AW-1:0];
                n_state  = gbos_pkg::S_FCHK;
            end
            gbos_pkg::S_FCHK: begin
                // Kept indices are ascending, so one pointer walks past them.
                kl_raddr = r_p[gbos_pkg::KEEP_AW-1:0];
                if (r_b >= r_count || r_kc >= r_want) begin
                    n_i     = '0;
                    n_state = gbos_pkg::S_ERD;
                end else if (r_p < r_g && kl_rdata == r_b[9:0]) begin
                    n_p     = r_p + 1'b1;
                    n_b     = r_b + 1'b1;
                    n_state = gbos_pkg::S_FRD;
                end else begin
                    kl_we = 1'b1;
                    n_kc  = r_kc + 1'b1;
                    n_b   = r_b + 1'b1;
                end
            end
            gbos_pkg::S_ERD: begin
                kl_raddr = r_i[gbos_pkg::KEEP_AW-1:0];
                n_state  = gbos_pkg::S_ELOAD;
            end
            gbos_pkg::S_ELOAD: begin
                n_out_idx   = kl_rdata;
                n_out_last  = (r_i + 1'b1 == r_kc);
                n_out_valid = 1'b1;
                n_i         = r_i + 1'b1;
                n_state     = gbos_pkg::S_EWAIT;
            end
            gbos_pkg::S_EWAIT: begin
                if (!i_stall) begin
                    n_out_valid = 1'b0;
                    if (r_out_last) begin
                        n_count = '0;
                        n_state = gbos_pkg::S_IDLE;
                    end else begin
                        n_state = gbos_pkg::S_ERD;
                    end
                end
            end
            default: n_state = gbos_pkg::S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

// ----- design/gbos_check.sv -----
// Port-level checker for the greedy box overlap suppression block, and its bind.
// Depends on greedy_box_overlap_suppression.
`default_nettype none
module gbos_check (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_valid,
    input wire logic       o_stall,
    input wire logic       i_last_box,
    input wire logic       o_valid,
    input wire logic       i_stall,
    input wire logic [9:0] o_selected_index,
    input wire logic       o_last_selected
);
    // A result item is held until taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_selected_index))
        else $error("result changed while stalled");

    // The final box starts a run that blocks further input.
    a_last_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_last_box |=> o_stall)
        else $error("input open after final box");

    // Results appear only while the input side is closed.
    a_out_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("result shown while loading");

    // After the final index is taken, nothing more is shown.
    a_end_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && o_last_selected |=> !o_valid && !o_stall)
        else $error("run did not end after final index");
endmodule

bind greedy_box_overlap_suppression gbos_check u_gbos_check (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
    .i_last_box(i_last_box), .o_valid(o_valid), .i_stall(i_stall),
    .o_selected_index(o_selected_index), .o_last_selected(o_last_selected)
);
`default_nettype wire

// ----- verif/greedy_box_overlap_suppression_tb.sv -----
// Self-checking testbench for the greedy box overlap suppression block.
// Depends on gbos_pkg and the greedy_box_overlap_suppression top level.
`timescale 1ns / 1ps
`default_nettype none
module greedy_box_overlap_suppression_tb;

    // One candidate box as the sender presents it.
    typedef struct packed {
        logic [15:0] left_x;
        logic [15:0] top_y;
        logic [15:0] right_x;
        logic [15:0] bottom_y;
        logic        last_box;
    } t_box_item;

    // One selected index as the block emits it.
    typedef struct packed {
        logic [9:0] index;
        logic       last;
    } t_pick;

    // A pending item is either a box or a marker that makes the driver hold
    // off, reconfigure, or wait until every expected index has come back.
    typedef enum logic [1:0] {
        ACT_BOX, ACT_DRAIN, ACT_CFG
    } t_act_kind;

    typedef struct packed {
        t_act_kind   kind;
        t_box_item   box;
        logic        cfg_idx;
        logic [16:0] cfg_data;
    } t_pending;

    localparam int WATCHDOG_LIMIT = 200000;
    localparam int SETTLE_CYCLES  = 64;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [15:0] i_left_x;
    logic [15:0] i_top_y;
    logic [15:0] i_right_x;
    logic [15:0] i_bottom_y;
    logic        i_last_box;
    logic        o_valid;
    logic        i_stall;
    logic [9:0]  o_selected_index;
    logic        o_last_selected;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [16:0] i_cfg_data;

    greedy_box_overlap_suppression u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_left_x         (i_left_x),
        .i_top_y          (i_top_y),
        .i_right_x        (i_right_x),
        .i_bottom_y       (i_bottom_y),
        .i_last_box       (i_last_box),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_selected_index (o_selected_index),
        .o_last_selected  (o_last_selected),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // Prediction state: our own copy of the box set and of the registers.
    // ------------------------------------------------------------------
    logic [63:0]     set_boxes [gbos_pkg::MAX_BOXES];
    int unsigned     set_size;
    logic [6:0]      keep_reg;
    logic [16:0]     thresh_reg;
    t_pick           picks_due [$];
    t_pending        pending [$];
    bit              failed;
    bit              stim_done;
    bit              quiet_stretch;   // turns off random idling on both sides

    function automatic logic [31:0] span(input logic [15:0] lo, input logic [15:0] hi);
        return (hi > lo) ? 32'(hi - lo) : 32'd0;
    endfunction

    // True when the IoU of two boxes exceeds the threshold, by cross-multiplying.
    function automatic bit too_close(input logic [63:0] a, input logic [63:0] b,
                                     input logic [16:0] thr);
        logic [15:0] l, t, r, d;
        logic [63:0] inter, area_a, area_b, uni;
        l = (a[15:0]  > b[15:0])  ? a[15:0]  : b[15:0];
        t = (a[31:16] > b[31:16]) ? a[31:16] : b[31:16];
        r = (a[47:32] < b[47:32]) ? a[47:32] : b[47:32];
        d = (a[63:48] < b[63:48]) ? a[63:48] : b[63:48];
        inter  = 64'(span(l, r)) * 64'(span(t, d));
        area_a = 64'(span(a[15:0], a[47:32])) * 64'(span(a[31:16], a[63:48]));
        area_b = 64'(span(b[15:0], b[47:32])) * 64'(span(b[31:16], b[63:48]));
        uni    = area_a + area_b - inter;
        return (inter * 64'd65536) > (64'(thr) * uni);
    endfunction

    // Greedy pass over the stored set, then the fill pass with the unkept
    // boxes in index order. The expected indices are appended to picks_due.
    task automatic predict_selection();
        int unsigned want;
        int unsigned kept [$];
        bit          marked [gbos_pkg::MAX_BOXES];
        bit          rejected;
        want = (keep_reg == 0) ? 1 : keep_reg;
        if (want > gbos_pkg::MAX_KEEP) want = gbos_pkg::MAX_KEEP;
        foreach (marked[k]) marked[k] = 1'b0;
        if (set_size != 0) begin
            kept.push_back(0);
            marked[0] = 1'b1;
            for (int unsigned b = 1; b < set_size && kept.size() < want; b++) begin
                rejected = 1'b0;
                foreach (kept[k])
                    if (too_close(set_boxes[kept[k]], set_boxes[b], thresh_reg))
                        rejected = 1'b1;
                if (!rejected) begin
                    kept.push_back(b);
                    marked[b] = 1'b1;
                end
            end
            for (int unsigned b = 0; b < set_size && kept.size() < want; b++) begin
                if (!marked[b]) begin
                    kept.push_back(b);
                    marked[b] = 1'b1;
                end
            end
        end
        foreach (kept[k])
            picks_due.push_back('{index: kept[k][9:0], last: (k == kept.size() - 1)});
        set_size = 0;
    endtask

    task automatic predict_box(input t_box_item bx);
        if (set_size < gbos_pkg::MAX_BOXES) begin
            set_boxes[set_size] = {bx.bottom_y, bx.right_x, bx.top_y, bx.left_x};
            set_size++;
        end
        if (bx.last_box) predict_selection();
    endtask

    // ------------------------------------------------------------------
    // Stimulus builders.
    // ------------------------------------------------------------------
    function automatic t_box_item rand_box(input bit last);
        t_box_item   bx;
        logic [15:0] x, y;
        int unsigned sel;
        sel = $urandom_range(0, 9);
        x = 16'($urandom());
        y = 16'($urandom());
        bx.left_x   = x;
        bx.top_y    = y;
        // Mostly well-formed boxes, some full-range noise including inverted ones.
        if (sel < 8) begin
            bx.right_x  = (x > 16'hFF00) ? 16'hFFFF : x + 16'($urandom_range(0, 255));
            bx.bottom_y = (y > 16'hFF00) ? 16'hFFFF : y + 16'($urandom_range(0, 255));
        end else begin
            bx.right_x  = 16'($urandom());
            bx.bottom_y = 16'($urandom());
        end
        bx.last_box = last;
        return bx;
    endfunction

    // Clustered boxes near a common anchor so that suppression actually fires.
    function automatic t_box_item near_box(input t_box_item anchor, input bit last);
        t_box_item bx;
        bx = anchor;
        bx.left_x   = anchor.left_x   + 16'($urandom_range(0, 20));
        bx.top_y    = anchor.top_y    + 16'($urandom_range(0, 20));
        bx.right_x  = anchor.right_x  + 16'($urandom_range(0, 20));
        bx.bottom_y = anchor.bottom_y + 16'($urandom_range(0, 20));
        bx.last_box = last;
        return bx;
    endfunction

    function automatic t_pending as_box(input t_box_item bx);
        t_pending p;
        p = '0;
        p.kind = ACT_BOX;
        p.box  = bx;
        return p;
    endfunction

    function automatic t_pending as_cfg(input logic idx, input logic [16:0] val);
        t_pending p;
        p = '0;
        p.kind     = ACT_CFG;
        p.cfg_idx  = idx;
        p.cfg_data = val;
        return p;
    endfunction

    function automatic t_pending as_drain();
        t_pending p;
        p = '0;
        p.kind = ACT_DRAIN;
        return p;
    endfunction

    function automatic t_box_item mk_box(input logic [15:0] l, input logic [15:0] t,
                                         input logic [15:0] r, input logic [15:0] d,
                                         input bit last);
        return '{left_x: l, top_y: t, right_x: r, bottom_y: d, last_box: last};
    endfunction

    initial begin
        t_box_item anchor;
        int unsigned n, sets;
        failed        = 1'b0;
        stim_done     = 1'b0;
        quiet_stretch = 1'b0;
        set_size      = 0;
        keep_reg      = 7'd64;
        thresh_reg    = 17'd32768;

        // Directed: a single-box set under reset settings.
        pending.push_back(as_box(mk_box(16'd0, 16'd0, 16'd10, 16'd10, 1'b1)));
        // Identical boxes at full extremes: suppressed at the default threshold,
        // then refilled in index order.
        pending.push_back(as_box(mk_box(16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 1'b0)));
        pending.push_back(as_box(mk_box(16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 1'b0)));
        pending.push_back(as_box(mk_box(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1)));
        // Keep count zero is treated as one.
        pending.push_back(as_drain());
        pending.push_back(as_cfg(gbos_pkg::CFG_KEEP_COUNT, 17'd0));
        pending.push_back(as_box(mk_box(16'd5, 16'd5, 16'd50, 16'd50, 1'b0)));
        pending.push_back(as_box(mk_box(16'd500, 16'd500, 16'd600, 16'd600, 1'b1)));
        // Keep count above the maximum saturates; inverted boxes and zero unions.
        pending.push_back(as_drain());
        pending.push_back(as_cfg(gbos_pkg::CFG_KEEP_COUNT, 17'd127));
        pending.push_back(as_cfg(gbos_pkg::CFG_THRESHOLD, 17'd0));
        pending.push_back(as_box(mk_box(16'd100, 16'd100, 16'd10, 16'd10, 1'b0)));
        pending.push_back(as_box(mk_box(16'd100, 16'd100, 16'd10, 16'd10, 1'b0)));
        pending.push_back(as_box(mk_box(16'd7, 16'd7, 16'd7, 16'd7, 1'b0)));
        pending.push_back(as_box(mk_box(16'd0, 16'd0, 16'd20, 16'd20, 1'b0)));
        pending.push_back(as_box(mk_box(16'd10, 16'd10, 16'd30, 16'd30, 1'b1)));
        // Threshold above one: nothing is ever suppressed.
        pending.push_back(as_drain());
        pending.push_back(as_cfg(gbos_pkg::CFG_THRESHOLD, 17'h1FFFF));
        pending.push_back(as_box(mk_box(16'd0, 16'd0, 16'd9, 16'd9, 1'b0)));
        pending.push_back(as_box(mk_box(16'd0, 16'd0, 16'd9, 16'd9, 1'b1)));
        pending.push_back(as_drain());
        pending.push_back(as_cfg(gbos_pkg::CFG_THRESHOLD, 17'd65536));
        pending.push_back(as_box(mk_box(16'd0, 16'd0, 16'd9, 16'd9, 1'b0)));
        pending.push_back(as_box(mk_box(16'd0, 16'd0, 16'd9, 16'd9, 1'b1)));

        // Random sets: small sets with clustered boxes, settings changed before every third set.
        n = 0;
        sets = 0;
        while (n < 300) begin
            int unsigned sz;
            pending.push_back(as_drain());
            if (sets % 3 == 0) begin
                int unsigned kc_pick;
                kc_pick = $urandom_range(0, 5);
                pending.push_back(as_cfg(gbos_pkg::CFG_KEEP_COUNT,
                    (kc_pick == 0) ? 17'd1 : (kc_pick == 1) ? 17'd64 :
                    (kc_pick == 2) ? 17'($urandom_range(65, 127)) :
                    17'($urandom_range(1, 8))));
                pending.push_back(as_cfg(gbos_pkg::CFG_THRESHOLD,
                    ($urandom_range(0, 4) == 0) ? 17'($urandom()) :
                    17'($urandom_range(0, 65536))));
            end
            sz = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
            anchor = rand_box(1'b0);
            for (int unsigned k = 0; k < sz; k++) begin
                bit last;
                last = (k == sz - 1);
                if ($urandom_range(0, 2) == 0)
                    pending.push_back(as_box(rand_box(last)));
                else
                    pending.push_back(as_box(near_box(anchor, last)));
            end
            n += sz;
            sets++;
        end
    end

    // ------------------------------------------------------------------
    // Driver: takes pending items in order, with random idle cycles.
    // ------------------------------------------------------------------
    int unsigned cycle_count;
    int unsigned idle_guard;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        // A long stretch without idling on either side.
        quiet_stretch <= (cycle_count > 3000 && cycle_count < 9000);
        if (!i_rst_n) begin
            i_valid    <= 1'b0;
            i_cfg_we   <= 1'b0;
            idle_guard <= 0;
        end else begin
            i_cfg_we <= 1'b0;
            if (i_valid && !o_stall) begin
                predict_box('{left_x: i_left_x, top_y: i_top_y, right_x: i_right_x,
                              bottom_y: i_bottom_y, last_box: i_last_box});
            end
            if (!i_valid || !o_stall) begin
                // The current item (if any) has been taken; choose the next step.
                if (pending.size() == 0) begin
                    i_valid   <= 1'b0;
                    stim_done <= 1'b1;
                end else if (pending[0].kind == ACT_DRAIN) begin
                    i_valid <= 1'b0;
                    // Hold off until every index is back, then let the block settle.
                    if (picks_due.size() != 0 || (i_valid && i_last_box)) begin
                        idle_guard <= 0;
                    end else if (idle_guard < SETTLE_CYCLES) begin
                        idle_guard <= idle_guard + 1;
                    end else begin
                        idle_guard <= 0;
                        void'(pending.pop_front());
                    end
                end else if (pending[0].kind == ACT_CFG) begin
                    i_valid    <= 1'b0;
                    i_cfg_we   <= 1'b1;
                    i_cfg_idx  <= pending[0].cfg_idx;
                    i_cfg_data <= pending[0].cfg_data;
                    if (pending[0].cfg_idx == gbos_pkg::CFG_KEEP_COUNT)
                        keep_reg <= pending[0].cfg_data[6:0];
                    else
                        thresh_reg <= pending[0].cfg_data;
                    void'(pending.pop_front());
                end else if (!quiet_stretch && $urandom_range(0, 99) < 30) begin
                    i_valid <= 1'b0;
                end else begin
                    i_valid    <= 1'b1;
                    i_left_x   <= pending[0].box.left_x;
                    i_top_y    <= pending[0].box.top_y;
                    i_right_x  <= pending[0].box.right_x;
                    i_bottom_y <= pending[0].box.bottom_y;
                    i_last_box <= pending[0].box.last_box;
                    void'(pending.pop_front());
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: random receiver stalls and comparison with the oldest index due.
    // ------------------------------------------------------------------
    int unsigned no_accept;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall   <= 1'b0;
            no_accept <= 0;
        end else begin
            i_stall <= !quiet_stretch && ($urandom_range(0, 99) < 30);
            if ((o_valid && !i_stall) || (i_valid && !o_stall) || i_cfg_we)
                no_accept <= 0;
            else
                no_accept <= no_accept + 1;
            if (o_valid && !i_stall) begin
                if (picks_due.size() == 0) begin
                    $display("%0t: unexpected index %0d last %0b", $time,
                             o_selected_index, o_last_selected);
                    failed <= 1'b1;
                end else begin
                    t_pick due;
                    due = picks_due.pop_front();
                    if (due.index !== o_selected_index) begin
                        $display("%0t: selected_index expected %0d actual %0d", $time,
                                 due.index, o_selected_index);
                        failed <= 1'b1;
                    end
                    if (due.last !== o_last_selected) begin
                        $display("%0t: last_selected expected %0b actual %0b", $time,
                                 due.last, o_last_selected);
                        failed <= 1'b1;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Reset, end of run and watchdog.
    // ------------------------------------------------------------------
    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_stall     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = 1'b0;
        i_cfg_data  = '0;
        i_left_x    = '0;
        i_top_y     = '0;
        i_right_x   = '0;
        i_bottom_y  = '0;
        i_last_box  = 1'b0;
        cycle_count = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (no_accept >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog expired with %0d indices outstanding", $time,
                         picks_due.size());
                $display("greedy_box_overlap_suppression regression: fail");
                $finish;
            end
            if (stim_done && picks_due.size() == 0 && !i_valid) begin
                repeat (SETTLE_CYCLES) @(posedge i_clk);
                if (!failed && picks_due.size() == 0)
                    $display("greedy_box_overlap_suppression regression: pass");
                else
                    $display("greedy_box_overlap_suppression regression: fail");
                $finish;
            end
        end
    end

endmodule
`default_nettype wire

// ----- files.f -----
design/gbos_pkg.sv
design/gbos_ram.sv
design/greedy_box_overlap_suppression.sv
design/gbos_check.sv
verif/greedy_box_overlap_suppression_tb.sv
